// ===== rtl/sd64_pkg.sv =====
// shared types and constants for the pipelined signed 64-bit divider
package sd64_pkg;

  localparam int unsigned Width = 64;
  localparam int unsigned Steps = Width;
  localparam int unsigned Latency = Steps + 2;

  typedef logic [Width-1:0] word_t;

  // payload carried from cell to cell
  typedef struct packed {
    logic  neg;
    word_t nq;
    word_t rem;
    word_t dvsr;
  } sd64_stage_t;

endpackage

// ===== rtl/sd64_cell.sv =====
// one restoring shift-and-subtract step of the divider array
module sd64_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid_i,
  input  sd64_pkg::sd64_stage_t stage_i,
  output logic                 valid_o,
  output sd64_pkg::sd64_stage_t stage_o
);

  logic                  valid_r;
  sd64_pkg::sd64_stage_t stage_r;
  sd64_pkg::sd64_stage_t stage_nxt;
  sd64_pkg::word_t       shifted;
  logic [sd64_pkg::Width:0] diff;
  logic                  ge;

  // nq holds unused dividend bits at the top and quotient bits filling from the bottom
  always_comb begin
    shifted = {stage_i.rem[sd64_pkg::Width-2:0], stage_i.nq[sd64_pkg::Width-1]};
    diff = {1'b0, shifted} - {1'b0, stage_i.dvsr};
    ge = ~diff[sd64_pkg::Width];
    stage_nxt.neg = stage_i.neg;
    stage_nxt.dvsr = stage_i.dvsr;
    stage_nxt.rem = ge ? diff[sd64_pkg::Width-1:0] : shifted;
    stage_nxt.nq = {stage_i.nq[sd64_pkg::Width-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
  end

  assign valid_o = valid_r;
  assign stage_o = stage_r;

endmodule

// ===== rtl/signed_divide_64.sv =====
// top level of the signed 64-bit divider: sign handling around a 64-cell array
// a request passes an operand stage, one register per array cell and an output stage
// throughput: one request per cycle, busy never rises
// reset: synchronous, active low, clears the valid bits of every stage
// results cannot be stalled: out_valid marks the quotient for one cycle
module signed_divide_64 (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [63:0] in_dividend,
  input  logic signed [63:0] in_divisor,
  output logic               out_valid,
  output logic signed [63:0] out_quotient
);

  logic                  valid0_r;
  sd64_pkg::sd64_stage_t stage0_r;
  sd64_pkg::sd64_stage_t stage0_nxt;
  sd64_pkg::word_t       a_u;
  sd64_pkg::word_t       b_u;
  logic                  valid_w [0:sd64_pkg::Steps];
  sd64_pkg::sd64_stage_t stage_w [0:sd64_pkg::Steps];
  logic                  out_valid_r;
  sd64_pkg::word_t       out_quotient_r;
  sd64_pkg::word_t       out_quotient_nxt;
  sd64_pkg::sd64_stage_t last;

  assign busy = 1'b0;

  // operand magnitudes and sign of the result
  always_comb begin
    a_u = in_dividend;
    b_u = in_divisor;
    stage0_nxt.neg = a_u[sd64_pkg::Width-1] ^ b_u[sd64_pkg::Width-1];
    stage0_nxt.nq = a_u[sd64_pkg::Width-1] ? (~a_u + 1'b1) : a_u;
    stage0_nxt.dvsr = b_u[sd64_pkg::Width-1] ? (~b_u + 1'b1) : b_u;
    stage0_nxt.rem = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid0_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      valid0_r <= start && !busy;
      out_valid_r <= valid_w[sd64_pkg::Steps];
    end
  end

  always_ff @(posedge clk) begin
    stage0_r <= stage0_nxt;
    out_quotient_r <= out_quotient_nxt;
  end

  assign valid_w[0] = valid0_r;
  assign stage_w[0] = stage0_r;

  for (genvar i = 0; i < sd64_pkg::Steps; i++) begin : g_cell
    sd64_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (valid_w[i]),
      .stage_i (stage_w[i]),
      .valid_o (valid_w[i+1]),
      .stage_o (stage_w[i+1])
    );
  end

  // the most negative over minus one wraps naturally here
  always_comb begin
    last = stage_w[sd64_pkg::Steps];
    out_quotient_nxt = last.neg ? (~last.nq + 1'b1) : last.nq;
  end

  assign out_valid = out_valid_r;
  assign out_quotient = out_quotient_r;

`ifndef SYNTH
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, sd64_pkg::Latency))
    else $error("quotient without a matching request");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    valid_w[sd64_pkg::Steps] && (last.dvsr != '0) |-> last.rem < last.dvsr)
    else $error("partial remainder not below divisor at end of array");

  a_zero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(start && (in_divisor == 64'sd0), sd64_pkg::Latency) |->
    ((out_quotient == -64'sd1) || (out_quotient == 64'sd1)))
    else $error("division by zero gave neither plus nor minus one");

  a_zero_dividend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(start && (in_dividend == 64'sd0) && (in_divisor != 64'sd0),
                       sd64_pkg::Latency) |-> out_quotient == 64'sd0)
    else $error("zero dividend gave a non-zero quotient");
`endif

endmodule

// ===== tb/signed_divide_64_test.sv =====
// self-checking testbench for the pipelined signed 64-bit divider
module signed_divide_64_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam sd64_pkg::word_t MinVal = {1'b1, {(sd64_pkg::Width-1){1'b0}}};
  localparam sd64_pkg::word_t MaxVal = ~MinVal;
  localparam sd64_pkg::word_t Ones = '1;
  localparam int unsigned RandomCount = 1425;
  localparam int unsigned CycleLimit = 600000;

  typedef struct packed {
    sd64_pkg::word_t dividend;
    sd64_pkg::word_t divisor;
    logic            known;
    sd64_pkg::word_t quotient;
  } div_row_t;

  // quotient typed in where it is plain, otherwise left to the predictor
  localparam div_row_t DirectedRows [0:24] = '{
    '{64'd0, 64'd1, 1'b1, 64'd0},
    '{64'd7, 64'd2, 1'b1, 64'd3},
    '{-64'sd7, 64'd2, 1'b1, -64'sd3},
    '{64'd7, -64'sd2, 1'b1, -64'sd3},
    '{-64'sd7, -64'sd2, 1'b1, 64'd3},
    '{MinVal, Ones, 1'b1, MinVal},
    '{MinVal, 64'd1, 1'b1, MinVal},
    '{MaxVal, 64'd1, 1'b1, MaxVal},
    '{MaxVal, Ones, 1'b1, MinVal + 64'd1},
    '{MinVal, MinVal, 1'b1, 64'd1},
    '{MaxVal, MinVal, 1'b1, 64'd0},
    '{MinVal, MaxVal, 1'b1, Ones},
    '{64'd5, 64'd0, 1'b1, Ones},
    '{-64'sd5, 64'd0, 1'b1, 64'd1},
    '{64'd0, 64'd0, 1'b1, Ones},
    '{MinVal, 64'd0, 1'b1, 64'd1},
    '{MaxVal, 64'd0, 1'b1, Ones},
    '{Ones, Ones, 1'b1, 64'd1},
    '{MinVal, 64'd2, 1'b1, 64'hc000_0000_0000_0000},
    '{64'd1, MaxVal, 1'b1, 64'd0},
    '{-64'sd6, 64'd7, 1'b1, 64'd0},
    '{64'd0, Ones, 1'b1, 64'd0},
    '{64'h0123_4567_89ab_cdef, 64'h0000_0000_1234_5678, 1'b0, 64'd0},
    '{64'hfedc_ba98_7654_3210, 64'h0000_0000_0000_0003, 1'b0, 64'd0},
    '{64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaab, 1'b0, 64'd0}
  };

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [63:0] in_dividend;
  logic signed [63:0] in_divisor;
  logic               out_valid;
  logic signed [63:0] out_quotient;

  sd64_pkg::word_t pending_quotients[$];
  sd64_pkg::word_t next_quotient;
  sd64_pkg::word_t oldest_quotient;
  int unsigned     fail_count;
  int unsigned     cycle_count;

  signed_divide_64 u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_dividend  (in_dividend),
    .in_divisor   (in_divisor),
    .out_valid    (out_valid),
    .out_quotient (out_quotient)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // truncating signed division; a zero divisor gives an all-ones magnitude
  function automatic sd64_pkg::word_t signed_quotient(sd64_pkg::word_t num,
                                                      sd64_pkg::word_t den);
    sd64_pkg::word_t num_mag;
    sd64_pkg::word_t den_mag;
    sd64_pkg::word_t mag_q;
    num_mag = num[sd64_pkg::Width-1] ? -num : num;
    den_mag = den[sd64_pkg::Width-1] ? -den : den;
    mag_q = (den_mag == '0) ? Ones : num_mag / den_mag;
    return (num[sd64_pkg::Width-1] ^ den[sd64_pkg::Width-1]) ? -mag_q : mag_q;
  endfunction

  function automatic sd64_pkg::word_t pick_operand();
    sd64_pkg::word_t v;
    bit              shaped;
    v = {$urandom, $urandom};
    shaped = 1'b1;
    case ($urandom_range(0, 9))
      0, 1, 2: shaped = 1'b0;
      3: v = v >> $urandom_range(1, 63);
      4: v = sd64_pkg::word_t'($urandom_range(0, 40));
      5: begin
        shaped = 1'b0;
        case ($urandom_range(0, 4))
          0: v = '0;
          1: v = MinVal;
          2: v = MaxVal;
          3: v = Ones;
          default: v = 64'd1;
        endcase
      end
      default: v = v >> $urandom_range(20, 50);
    endcase
    if (shaped && $urandom_range(0, 1) == 1)
      v = -v;
    return v;
  endfunction

  task automatic send_request(sd64_pkg::word_t num, sd64_pkg::word_t den, logic known,
                              sd64_pkg::word_t quo);
    @(negedge clk);
    start <= 1'b1;
    in_dividend <= num;
    in_divisor <= den;
    next_quotient = known ? quo : signed_quotient(num, den);
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic idle_cycles(int unsigned n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
      in_dividend <= {$urandom, $urandom};
      in_divisor <= {$urandom, $urandom};
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    else if (r < 92)
      return $urandom_range(1, 3);
    else
      return $urandom_range(10, 80);
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else if (rst_n) begin
      if (start && busy === 1'b0)
        pending_quotients.push_back(next_quotient);
      if (out_valid === 1'b1) begin
        if (pending_quotients.size() == 0) begin
          $error("quotient: none expected, got %h", out_quotient);
          fail_count++;
        end else begin
          oldest_quotient = pending_quotients.pop_front();
          if (out_quotient !== oldest_quotient) begin
            $error("quotient: expected %h, got %h", oldest_quotient, out_quotient);
            fail_count++;
          end
        end
      end else if (out_valid !== 1'b0) begin
        $error("out_valid: expected 0 or 1, got %b", out_valid);
        fail_count++;
      end
    end
  end

  initial begin
    bit no_gaps;
    rst_n = 1'b0;
    start = 1'b0;
    in_dividend = '0;
    in_divisor = '0;
    next_quotient = '0;
    fail_count = 0;
    cycle_count = 0;
    no_gaps = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DirectedRows[row]) begin
      send_request(DirectedRows[row].dividend, DirectedRows[row].divisor,
                   DirectedRows[row].known, DirectedRows[row].quotient);
      idle_cycles($urandom_range(0, 2));
    end

    for (int unsigned i = 0; i < RandomCount; i++) begin
      // stretches of back-to-back requests between gappy ones
      if (i % 50 == 0)
        no_gaps = ($urandom_range(0, 3) == 0);
      if (i == RandomCount / 2) begin
        idle_cycles(1);
        while (pending_quotients.size() != 0) @(negedge clk);
      end
      send_request(pick_operand(), pick_operand(), 1'b0, '0);
      if (!no_gaps)
        idle_cycles(pick_gap());
    end

    idle_cycles(1);
    while (pending_quotients.size() != 0) @(posedge clk);
    // catch any stray quotient still in the array
    repeat (sd64_pkg::Latency + 4) @(posedge clk);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sd64_pkg.sv
rtl/sd64_cell.sv
rtl/signed_divide_64.sv
tb/signed_divide_64_test.sv
